FILE: rtl/sits_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ID table search: shared types and constants
// Command and status bundles between the controller and the datapath, and
// the fixed widths of the transaction fields.
// ----------------------------------------------------------------------------
package sits_pkg;

    localparam int ID_W    = 31;
    localparam int PROBE_W = 3;
    localparam int HELD_W  = 4;

    typedef struct packed {
        logic load;
        logic ins_rd;
        logic ins_shift;
        logic ins_key;
        logic srch_rd;
        logic srch_upd;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic rd_left;
        logic dv;
        logic q_gt;
        logic eq;
        logic live_after;
    } t_stat;

endpackage

FILE: rtl/sits_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ID table search: datapath
// Ordered ID memory with one write and one registered read port, fill count,
// insert pointers, binary search bounds and result registers.
// ----------------------------------------------------------------------------
module sits_dpath #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sits_pkg::t_cmd               i_cmd,
    output sits_pkg::t_stat              o_stat,
    input  logic                         i_action,
    input  logic [sits_pkg::ID_W-1:0]    i_id_value,
    output logic                         o_status,
    output logic                         o_found,
    output logic [sits_pkg::PROBE_W-1:0] o_probe_count,
    output logic [sits_pkg::HELD_W-1:0]  o_entries_held
);
    import sits_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = $clog2(CW + 1);

    logic [ID_W-1:0] r_mem [TABLE_DEPTH];
    logic [ID_W-1:0] r_q;
    logic            r_dv;
    logic [ID_W-1:0] r_key;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   r_lo;
    logic [CW-1:0]   r_hx;
    logic [AW-1:0]   r_mid;
    logic [AW-1:0]   r_rptr;
    logic [AW-1:0]   r_wptr;
    logic            r_rd_left;
    logic [PW-1:0]   r_probes;
    logic            r_found;
    logic            r_reject;

    logic [CW:0]     w_sum;
    logic [AW-1:0]   w_mid;
    logic [CW-1:0]   w_mid_ext;
    logic [CW-1:0]   w_mid_p1;
    logic            w_lt;
    logic            w_eq;
    logic [AW-1:0]   w_raddr;
    logic            w_wen;
    logic [ID_W-1:0] w_wdata;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hx} - 1'b1;
    assign w_mid     = w_sum[AW:1];
    assign w_mid_ext = CW'(r_mid);
    assign w_mid_p1  = w_mid_ext + 1'b1;
    assign w_lt      = r_key < r_q;
    assign w_eq      = r_key == r_q;
    assign w_raddr   = i_cmd.ins_rd ? r_rptr : w_mid;
    assign w_wen     = i_cmd.ins_shift | i_cmd.ins_key;
    assign w_wdata   = i_cmd.ins_shift ? r_q : r_key;

    assign o_stat.full       = r_fill == CW'(TABLE_DEPTH);
    assign o_stat.empty      = r_fill == '0;
    assign o_stat.rd_left    = r_rd_left;
    assign o_stat.dv         = r_dv;
    assign o_stat.q_gt       = r_q > r_key;
    assign o_stat.eq         = w_eq;
    assign o_stat.live_after = w_lt ? (r_lo < w_mid_ext) : (w_mid_p1 < r_hx);

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_wptr] <= w_wdata;
        end
        r_q <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_dv   <= 1'b0;
        end else begin
            r_dv <= i_cmd.ins_rd | i_cmd.srch_rd;
            if (i_cmd.ins_key) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_id_value;
            r_reject  <= !i_action && o_stat.full;
            r_found   <= 1'b0;
            r_probes  <= '0;
            r_lo      <= '0;
            r_hx      <= r_fill;
            r_rptr    <= AW'(r_fill - 1'b1);
            r_wptr    <= AW'(r_fill);
            r_rd_left <= r_fill != '0;
        end
        if (i_cmd.ins_rd) begin
            r_rptr    <= r_rptr - 1'b1;
            r_rd_left <= r_rptr != '0;
        end
        if (i_cmd.ins_shift) begin
            r_wptr <= r_wptr - 1'b1;
        end
        if (i_cmd.srch_rd) begin
            r_mid <= w_mid;
        end
        if (i_cmd.srch_upd) begin
            r_probes <= r_probes + 1'b1;
            if (w_eq) begin
                r_found <= 1'b1;
            end else if (w_lt) begin
                r_hx <= w_mid_ext;
            end else begin
                r_lo <= w_mid_p1;
            end
        end
    end

    assign o_status       = r_reject;
    assign o_found        = r_found;
    assign o_probe_count  = PROBE_W'(r_probes);
    assign o_entries_held = HELD_W'(r_fill);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_fill_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_key |=> r_fill == $past(r_fill) + 1'b1)
        else $error("insert did not advance fill count");
`endif

endmodule

FILE: rtl/sits_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ID table search: controller
// Sequences ordered insert and binary search steps and marks the result.
// ----------------------------------------------------------------------------
module sits_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_action,
    output logic            busy,
    output logic            o_valid,
    input  sits_pkg::t_stat i_stat,
    output sits_pkg::t_cmd  o_cmd
);
    import sits_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_SRD  = 5'b00100,
        S_SCMP = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (!i_action) begin
                        n_state = i_stat.full ? S_DONE : S_INS;
                    end else begin
                        n_state = i_stat.empty ? S_DONE : S_SRD;
                    end
                end
            end
            S_INS: begin
                o_cmd.ins_rd = i_stat.rd_left;
                if (i_stat.dv) begin
                    if (i_stat.q_gt) begin
                        o_cmd.ins_shift = 1'b1;
                    end else begin
                        o_cmd.ins_key = 1'b1;
                        n_state       = S_DONE;
                    end
                end else if (!i_stat.rd_left) begin
                    o_cmd.ins_key = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SRD: begin
                o_cmd.srch_rd = 1'b1;
                n_state       = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.srch_upd = 1'b1;
                n_state = (!i_stat.eq && i_stat.live_after) ? S_SRD : S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = r_state != S_IDLE;
    assign o_valid = r_state == S_DONE;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy held after result strobe");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");
`endif

endmodule

FILE: rtl/sorted_id_table_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted ID table search
// Ordered table of up to TABLE_DEPTH IDs with ordered insert and binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_action and i_id_value with start high; the transaction is taken
//   at the rising edge where start is high and busy is low. Action 0 adds the
//   ID after any equal IDs, action 1 looks it up over the filled entries.
//   Exactly one result per transaction appears for one cycle with o_valid
//   high: o_status (add rejected, table full), o_found, o_probe_count and
//   o_entries_held. The receiver cannot stall; the result is gone next cycle.
//   Sequence from accept to strobe:
//     lookup: each probe is a memory read then a compare, strobe in the
//             cycle after the last compare; empty table: straight to strobe.
//     add:    the shift loop moves the entries above the ID up one place,
//             one entry per cycle through the memory read and write ports;
//             rejected add: straight to strobe.
//   busy drops the cycle after the strobe; the next start is taken then.
//   Reset (i_rst_n low, synchronous) empties the table and returns to idle.
// ----------------------------------------------------------------------------
module sorted_id_table_search #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [sits_pkg::ID_W-1:0]    i_id_value,
    output logic                         o_valid,
    output logic                         o_status,
    output logic                         o_found,
    output logic [sits_pkg::PROBE_W-1:0] o_probe_count,
    output logic [sits_pkg::HELD_W-1:0]  o_entries_held
);
    import sits_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sits_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .busy     (busy),
        .o_valid  (o_valid),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    sits_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_action       (i_action),
        .i_id_value     (i_id_value),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_probe_count  (o_probe_count),
        .o_entries_held (o_entries_held)
    );

endmodule

FILE: sim/tb_sorted_id_table_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted ID table search block
// Drives directed add and lookup commands, then random ones in bursts and
// gaps. A scoreboard class keeps its own ordered copy of the table and runs
// the same insert and binary search to work out each response. Every strobed
// response is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_sorted_id_table_search;

    import sits_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int RANDOM_CMDS = 1300;
    localparam int DRAIN_CYCLES = 24;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef struct packed {
        logic              status;
        logic              found;
        logic [PROBE_W-1:0] probes;
        logic [HELD_W-1:0]  entries;
    } t_search_resp;

    class id_table_scoreboard;
        logic [ID_W-1:0] id_list[TABLE_DEPTH];
        int              held;
        t_search_resp    expected_q[$];
        int unsigned     mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void note_command(logic action, logic [ID_W-1:0] key);
            t_search_resp r;
            int lo;
            int hi;
            int mid;
            int pos;
            r = '0;
            if (action == ACT_ADD) begin
                if (held >= TABLE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    pos = held;
                    while (pos > 0 && id_list[pos-1] > key) begin
                        id_list[pos] = id_list[pos-1];
                        pos--;
                    end
                    id_list[pos] = key;
                    held++;
                end
            end else begin
                lo = 0;
                hi = held - 1;
                while (lo <= hi && !r.found) begin
                    mid = (lo + hi) / 2;
                    r.probes = r.probes + 1'b1;
                    if (key < id_list[mid]) begin
                        hi = mid - 1;
                    end else if (key > id_list[mid]) begin
                        lo = mid + 1;
                    end else begin
                        r.found = 1'b1;
                    end
                end
            end
            r.entries = held[HELD_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(t_search_resp got);
            t_search_resp exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected response status=%0b found=%0b probes=%0d held=%0d",
                             $realtime, got.status, got.found, got.probes, got.entries);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status || got.found !== exp_r.found ||
                got.probes !== exp_r.probes || got.entries !== exp_r.entries) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp status=%0b found=%0b probes=%0d held=%0d, %s",
                             $realtime, exp_r.status, exp_r.found, exp_r.probes,
                             exp_r.entries,
                             $sformatf("got status=%0b found=%0b probes=%0d held=%0d",
                                       got.status, got.found, got.probes, got.entries));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_action;
    logic [ID_W-1:0]    i_id_value;
    logic               o_valid;
    logic               o_status;
    logic               o_found;
    logic [PROBE_W-1:0] o_probe_count;
    logic [HELD_W-1:0]  o_entries_held;

    id_table_scoreboard sb;

    sorted_id_table_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_id_value     (i_id_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_probe_count  (o_probe_count),
        .o_entries_held (o_entries_held)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result({o_status, o_found, o_probe_count, o_entries_held});
    end

    task automatic send_command(input logic action, input logic [ID_W-1:0] key);
        @(negedge i_clk);
        start      <= 1'b1;
        i_action   <= action;
        i_id_value <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(action, key);
    endtask

    task automatic idle_for(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_responses();
        idle_for(1);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int               issued;
        int               burst;
        int               sel;
        logic             action;
        logic [ID_W-1:0]  key;
        logic [31:0]      raw;

        sb = new();
        start      = 1'b0;
        i_action   = ACT_ADD;
        i_id_value = '0;
        i_rst_n    = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table lookups
        send_command(ACT_LOOKUP, '0);
        send_command(ACT_LOOKUP, ID_MAX);
        send_command(ACT_ADD, 31'd1000);
        send_command(ACT_LOOKUP, 31'd1000);
        send_command(ACT_LOOKUP, 31'd999);
        send_command(ACT_ADD, ID_MAX);
        send_command(ACT_ADD, '0);
        // duplicate lands after the equal entry
        send_command(ACT_ADD, 31'd1000);
        send_command(ACT_LOOKUP, '0);
        send_command(ACT_LOOKUP, ID_MAX);
        send_command(ACT_LOOKUP, 31'd1001);
        send_command(ACT_ADD, 31'd500);
        send_command(ACT_ADD, ID_MAX);
        send_command(ACT_ADD, '0);
        send_command(ACT_ADD, 31'h2AAA_AAAA);
        // full table rejects the add
        send_command(ACT_ADD, 31'h5555_5555);
        send_command(ACT_ADD, '0);
        send_command(ACT_LOOKUP, '0);
        send_command(ACT_LOOKUP, ID_MAX);
        send_command(ACT_LOOKUP, 31'd1000);
        send_command(ACT_LOOKUP, 31'd500);
        send_command(ACT_LOOKUP, 31'h2AAA_AAAA);
        send_command(ACT_LOOKUP, 31'h5555_5555);
        send_command(ACT_LOOKUP, 31'd1);
        send_command(ACT_LOOKUP, ID_MAX - 1'b1);

        issued = 0;
        while (issued < RANDOM_CMDS) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst; b++) begin
                raw = $urandom;
                action = ($urandom_range(0, 99) < 15) ? ACT_ADD : ACT_LOOKUP;
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    key = sb.id_list[$urandom_range(0, TABLE_DEPTH - 1)];
                end else if (sel < 7) begin
                    key = sb.id_list[$urandom_range(0, TABLE_DEPTH - 1)];
                    key = raw[0] ? key + 1'b1 : key - 1'b1;
                end else begin
                    key = raw[ID_W-1:0] >> $urandom_range(0, ID_W - 1);
                    if (sel == 9)
                        key = raw[ID_W-1:0];
                end
                send_command(action, key);
                issued++;
            end
            // hold back until every response is in
            if (issued >= 600 && issued < 600 + burst)
                drain_responses();
            else if (!(issued > 200 && issued < 400) && $urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 12));
        end

        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
